// ===== rtl/dhpf_pkg.sv =====
// ----------------------------------------------------------------------------
// dhpf_pkg
// Shared types and constants for the drum hit pulse frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dhpf_pkg;

  // Request commands
  localparam logic [1:0] CMD_BUILD = 2'd0;
  localparam logic [1:0] CMD_GATE  = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  localparam int SLOT_COUNT = 8;    // pulse-stretched sensor slots, 1..16
  localparam int HIT_W      = 8;    // slots that can receive a hit / report a peak
  localparam int HOLD_W     = 20;
  localparam int TIME_W     = 64;
  localparam int COIN_W     = 16;
  localparam int DIG_W      = 16;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 20'd18000;

  localparam logic [DIG_W-1:0] DIG_TEST    = 16'h0080;
  localparam logic [DIG_W-1:0] DIG_ENTER   = 16'h0200;
  localparam logic [DIG_W-1:0] DIG_DOWN    = 16'h1000;
  localparam logic [DIG_W-1:0] DIG_UP      = 16'h2000;
  localparam logic [DIG_W-1:0] DIG_SERVICE = 16'h4000;

  typedef struct packed {
    logic [1:0]        command;
    logic              value_on;
    logic              advance;
    logic [TIME_W-1:0] now_us;
    logic [3:0]        held_buttons;
    logic              other_held;
    logic [7:0]        coin_pulses;
    logic [7:0]        test_pulses;
    logic [HIT_W-1:0]  hit_mask;
  } in_item_t;

  typedef struct packed {
    logic [DIG_W-1:0]  digital_word;
    logic [COIN_W-1:0] coin_total;
    logic [HIT_W-1:0]  peak_mask;
  } frame_t;

  // Control from the request decoder to the slot array
  typedef struct packed {
    logic step;   // advancing build: evaluate deadlines and take hits
    logic clear;  // gating on: drop every running pulse
  } slot_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/dhpf_if.sv =====
// ----------------------------------------------------------------------------
// dhpf_if
// Valid/ready channels for requests and frames.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhpf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       value_on;
  logic       advance;
  logic [dhpf_pkg::TIME_W-1:0] now_us;
  logic [3:0] held_buttons;
  logic       other_held;
  logic [7:0] coin_pulses;
  logic [7:0] test_pulses;
  logic [dhpf_pkg::HIT_W-1:0] hit_mask;

  modport source (output valid, command, value_on, advance, now_us, held_buttons,
                  other_held, coin_pulses, test_pulses, hit_mask, input ready);
  modport sink   (input valid, command, value_on, advance, now_us, held_buttons,
                  other_held, coin_pulses, test_pulses, hit_mask, output ready);
endinterface

interface dhpf_out_if;
  logic valid;
  logic ready;
  logic [dhpf_pkg::DIG_W-1:0]  digital_word;
  logic [dhpf_pkg::COIN_W-1:0] coin_total;
  logic [dhpf_pkg::HIT_W-1:0]  peak_mask;

  modport source (output valid, digital_word, coin_total, peak_mask, input ready);
  modport sink   (input valid, digital_word, coin_total, peak_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/dhpf_slots.sv =====
// ----------------------------------------------------------------------------
// dhpf_slots
// Per-slot pulse stretcher: active bit plus a 64-bit deadline per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module dhpf_slots (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dhpf_pkg::slot_ctrl_t              ctrl,
  input  wire logic [dhpf_pkg::TIME_W-1:0]       now_us,
  input  wire logic [dhpf_pkg::HOLD_W-1:0]       hold_us,
  input  wire logic [dhpf_pkg::HIT_W-1:0]        hits,
  output logic      [dhpf_pkg::SLOT_COUNT-1:0]   high
);

  logic [dhpf_pkg::SLOT_COUNT-1:0] active_r;
  logic [dhpf_pkg::SLOT_COUNT-1:0] active_nxt;
  logic [dhpf_pkg::TIME_W-1:0]     deadline_r [dhpf_pkg::SLOT_COUNT];
  logic [dhpf_pkg::TIME_W-1:0]     deadline_nxt;

  // One deadline serves every slot that takes a hit on this beat
  assign deadline_nxt = now_us + {{(dhpf_pkg::TIME_W-dhpf_pkg::HOLD_W){1'b0}}, hold_us};

  for (genvar i = 0; i < dhpf_pkg::SLOT_COUNT; i++) begin : g_slot
    logic hit;
    logic running;

    if (i < dhpf_pkg::HIT_W) begin : g_hit
      assign hit = hits[i];
    end else begin : g_nohit
      assign hit = 1'b0;
    end

    assign running = now_us < deadline_r[i];

    // A slot past its deadline spends this beat as the forced-low sample
    assign high[i] = active_r[i] ? running : hit;

    always_comb begin
      active_nxt[i] = active_r[i];
      if (ctrl.clear) begin
        active_nxt[i] = 1'b0;
      end else if (ctrl.step) begin
        active_nxt[i] = active_r[i] ? running : hit;
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.step && !active_r[i] && hit) begin
        deadline_r[i] <= deadline_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      active_r <= active_nxt;
    end
  end

  a_clear_drops_all: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> active_r == '0)
    else $error("pulse still active after gating on");

endmodule

`default_nettype wire

// ===== rtl/dhpf_core.sv =====
// ----------------------------------------------------------------------------
// dhpf_core
// Request decode, gating, release gate, coin/test state and frame assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module dhpf_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire dhpf_pkg::in_item_t           item,
  input  wire logic [dhpf_pkg::HOLD_W-1:0]  hold_us,
  output logic                              has_result,
  output dhpf_pkg::frame_t                  frame
);

  logic gated_r, gated_nxt;
  logic release_r, release_nxt;
  logic test_r, test_nxt;
  logic [dhpf_pkg::COIN_W-1:0] coin_r, coin_nxt;
  logic saved_valid_r, saved_valid_nxt;
  dhpf_pkg::frame_t saved_r, saved_nxt;

  logic is_build, is_gate;
  logic replay, adv, quiet, suppress;
  logic [3:0] levels;
  logic [7:0] coins;
  logic test_odd;
  logic [dhpf_pkg::HIT_W-1:0] hits;
  logic [dhpf_pkg::SLOT_COUNT-1:0] high;
  logic [dhpf_pkg::HIT_W-1:0] peaks;
  logic [dhpf_pkg::DIG_W-1:0] digital;
  dhpf_pkg::slot_ctrl_t slot_ctrl;

  assign is_build = item.command == dhpf_pkg::CMD_BUILD;
  assign is_gate  = item.command == dhpf_pkg::CMD_GATE;

  assign replay = is_build && !gated_r && !item.advance && saved_valid_r;
  assign adv    = is_build && item.advance;

  assign quiet = (item.held_buttons == '0) && !item.other_held &&
                 (item.coin_pulses == '0) && (item.test_pulses == '0) &&
                 (item.hit_mask == '0);
  // Release gate clears on a quiet request and lets that request through
  assign suppress = gated_r || (release_r && !quiet);

  assign levels   = suppress ? '0 : item.held_buttons;
  assign coins    = suppress ? '0 : item.coin_pulses;
  assign test_odd = suppress ? 1'b0 : item.test_pulses[0];
  assign hits     = suppress ? '0 : item.hit_mask;

  assign slot_ctrl.step  = fire && adv;
  assign slot_ctrl.clear = fire && is_gate && item.value_on;

  dhpf_slots u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (slot_ctrl),
    .now_us  (item.now_us),
    .hold_us (hold_us),
    .hits    (hits),
    .high    (high)
  );

  for (genvar j = 0; j < dhpf_pkg::HIT_W; j++) begin : g_peak
    if (j < dhpf_pkg::SLOT_COUNT) begin : g_on
      assign peaks[j] = adv && high[j];
    end else begin : g_off
      assign peaks[j] = 1'b0;
    end
  end

  always_comb begin
    gated_nxt       = gated_r;
    release_nxt     = release_r;
    test_nxt        = test_r;
    coin_nxt        = coin_r;
    saved_valid_nxt = saved_valid_r;
    saved_nxt       = saved_r;
    case (item.command)
      dhpf_pkg::CMD_GATE: begin
        gated_nxt = item.value_on;
        if (item.value_on) begin
          saved_nxt       = '0;
          saved_valid_nxt = 1'b1;
          release_nxt     = 1'b0;
        end else if (gated_r) begin
          release_nxt = 1'b1;
        end
      end
      dhpf_pkg::CMD_TEST: begin
        test_nxt = item.value_on;
      end
      dhpf_pkg::CMD_BUILD: begin
        if (!replay) begin
          if (release_r && quiet) begin
            release_nxt = 1'b0;
          end
          if (adv) begin
            coin_nxt = coin_r + {8'b0, coins};
            if (test_odd) begin
              test_nxt = !test_r;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    digital = '0;
    if (test_nxt)  digital = digital | dhpf_pkg::DIG_TEST;
    if (levels[0]) digital = digital | dhpf_pkg::DIG_ENTER;
    if (levels[1]) digital = digital | dhpf_pkg::DIG_DOWN;
    if (levels[2]) digital = digital | dhpf_pkg::DIG_UP;
    if (levels[3]) digital = digital | dhpf_pkg::DIG_SERVICE;
  end

  always_comb begin
    if (replay) begin
      frame = saved_r;
    end else begin
      frame.digital_word = digital;
      frame.coin_total   = coin_nxt;
      frame.peak_mask    = peaks;
    end
  end

  assign has_result = is_build;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gated_r       <= 1'b0;
      release_r     <= 1'b0;
      test_r        <= 1'b0;
      coin_r        <= '0;
      saved_valid_r <= 1'b0;
      saved_r       <= '0;
    end else if (fire) begin
      gated_r       <= gated_nxt;
      release_r     <= release_nxt;
      test_r        <= test_nxt;
      coin_r        <= coin_nxt;
      saved_valid_r <= (adv && !replay) ? 1'b1 : saved_valid_nxt;
      saved_r       <= (adv && !replay) ? frame : saved_nxt;
    end
  end

  a_gate_on: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_gate && item.value_on |=> gated_r && saved_valid_r && !release_r)
    else $error("gating on did not reset frame state");

  a_gated_coins_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_build && gated_r |=> coin_r == $past(coin_r))
    else $error("coins counted while gated");

  a_replay_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    fire && replay |=> coin_r == $past(coin_r) && release_r == $past(release_r))
    else $error("replay changed state");

endmodule

`default_nettype wire

// ===== rtl/drum_hit_pulse_frame_builder.sv =====
// ----------------------------------------------------------------------------
// drum_hit_pulse_frame_builder
// Builds one input frame per build request from a pad snapshot, with drum pulses.
// ----------------------------------------------------------------------------
// Path: a build request accepted on in_ch is held in the input register, then
//   its frame is registered in the frame register and presented on out_ch.
// Throughput: one request per cycle while out_ch takes frames; each item sits
//   in the input register; the frame register frees while the sink takes it.
// Reset: synchronous, active low; clears all control state, pulses and the
//   coin counter and loads hold_r with 18000. No clearing pass.
`default_nettype none

module drum_hit_pulse_frame_builder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [dhpf_pkg::HOLD_W-1:0] cfg_wr_data,
  dhpf_in_if.sink                          in_ch,
  dhpf_out_if.source                       out_ch
);

  logic [dhpf_pkg::HOLD_W-1:0] hold_r;
  logic                        req_valid_r, req_valid_nxt;
  dhpf_pkg::in_item_t          req_r;
  logic                        out_valid_r, out_valid_nxt;
  dhpf_pkg::frame_t            out_r;

  logic             fire, has_result, out_free, in_take;
  dhpf_pkg::frame_t frame;

  assign out_free = !out_valid_r || out_ch.ready;
  assign fire     = req_valid_r && (!has_result || out_free);
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !req_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= dhpf_pkg::HOLD_RESET;
    end else if (cfg_wr_en) begin
      hold_r <= cfg_wr_data;
    end
  end

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_take) begin
      req_valid_nxt = 1'b1;
    end else if (fire) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.command      <= in_ch.command;
      req_r.value_on     <= in_ch.value_on;
      req_r.advance      <= in_ch.advance;
      req_r.now_us       <= in_ch.now_us;
      req_r.held_buttons <= in_ch.held_buttons;
      req_r.other_held   <= in_ch.other_held;
      req_r.coin_pulses  <= in_ch.coin_pulses;
      req_r.test_pulses  <= in_ch.test_pulses;
      req_r.hit_mask     <= in_ch.hit_mask;
    end
  end

  dhpf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (req_r),
    .hold_us    (hold_r),
    .has_result (has_result),
    .frame      (frame)
  );

  // Hold the frame until the sink takes the beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_r <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digital_word = out_r.digital_word;
  assign out_ch.coin_total   = out_r.coin_total;
  assign out_ch.peak_mask    = out_r.peak_mask;

  a_req_kept: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r && !fire |=> req_valid_r && req_r == $past(req_r))
    else $error("pending request lost");

endmodule

`default_nettype wire
